// File: rtl/point_transform_3d_defines.svh
// ----------------------------------------------------------------------------
// Point transform 3D assertion macros
// Shared property shorthands for the transform pipeline checks.
// ----------------------------------------------------------------------------
`ifndef POINT_TRANSFORM_3D_DEFINES_SVH
`define POINT_TRANSFORM_3D_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PT3_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PT3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pt3_pkg.sv
// ----------------------------------------------------------------------------
// Point transform 3D package
// Types, register indexes, mode codes and the per-lane mode decoder.
// ----------------------------------------------------------------------------
package pt3_pkg;

   localparam int NUM_LANES = 3;
   localparam int FRAC_BITS = 16;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [32:0] diff_type;
   typedef logic signed [19:0] factor_type;
   typedef logic signed [52:0] prod_type;
   typedef logic signed [53:0] sum_type;
   typedef logic signed [38:0] wide_type;
   typedef logic [2:0]         mode_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [31:0]        csr_data_type;
   typedef logic [1:0]         lane_idx_type;

   typedef coord_type [NUM_LANES-1:0] coord_vec_type;
   typedef diff_type  [NUM_LANES-1:0] diff_vec_type;
   typedef wide_type  [NUM_LANES-1:0] wide_vec_type;

   localparam lane_idx_type LANE_X = 2'd0;
   localparam lane_idx_type LANE_Y = 2'd1;
   localparam lane_idx_type LANE_Z = 2'd2;

   localparam mode_type MODE_MOVE  = 3'd0;
   localparam mode_type MODE_SCALE = 3'd1;
   localparam mode_type MODE_ROT_X = 3'd2;
   localparam mode_type MODE_ROT_Y = 3'd3;
   localparam mode_type MODE_ROT_Z = 3'd4;

   localparam csr_index_type REG_MODE     = 3'd0;
   localparam csr_index_type REG_OFFSET_X = 3'd1;
   localparam csr_index_type REG_OFFSET_Y = 3'd2;
   localparam csr_index_type REG_OFFSET_Z = 3'd3;
   localparam csr_index_type REG_FACTOR_A = 3'd4;
   localparam csr_index_type REG_FACTOR_B = 3'd5;

   localparam factor_type FACTOR_ONE = 20'sd65536;
   localparam coord_type  COORD_MAX  = 32'sh7fff_ffff;
   localparam coord_type  COORD_MIN  = 32'sh8000_0000;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_MOVE,
      KIND_XFORM
   } kind_type;

   typedef struct packed {
      kind_type     kind;
      lane_idx_type b_src;
      logic         b_sub;
      logic         b_en;
   } lane_ctrl_type;

   typedef lane_ctrl_type [NUM_LANES-1:0] lane_ctrl_vec_type;

   typedef struct packed {
      mode_type      mode;
      coord_vec_type off;
      factor_type    fa;
      factor_type    fb;
   } cfg_type;

   // Per-lane operation in scale and off-axis rotate lanes: own centered value times
   // factor_a, plus or minus (rotate only) one other lane's centered value times factor_b.
   function automatic lane_ctrl_type lane_decode(mode_type mode, lane_idx_type lane);
      lane_ctrl_type ctrl;
      ctrl.kind  = KIND_PASS;
      ctrl.b_src = lane;
      ctrl.b_sub = 1'b0;
      ctrl.b_en  = 1'b0;
      unique case (mode)
         MODE_MOVE:  ctrl.kind = KIND_MOVE;
         MODE_SCALE: ctrl.kind = KIND_XFORM;
         MODE_ROT_X: begin
            if (lane != LANE_X) begin
               ctrl.kind  = KIND_XFORM;
               ctrl.b_en  = 1'b1;
               ctrl.b_src = (lane == LANE_Y) ? LANE_Z : LANE_Y;
               ctrl.b_sub = (lane == LANE_Z);
            end
         end
         MODE_ROT_Y: begin
            if (lane != LANE_Y) begin
               ctrl.kind  = KIND_XFORM;
               ctrl.b_en  = 1'b1;
               ctrl.b_src = (lane == LANE_X) ? LANE_Z : LANE_X;
               ctrl.b_sub = (lane == LANE_X);
            end
         end
         MODE_ROT_Z: begin
            if (lane != LANE_Z) begin
               ctrl.kind  = KIND_XFORM;
               ctrl.b_en  = 1'b1;
               ctrl.b_src = (lane == LANE_X) ? LANE_Y : LANE_X;
               ctrl.b_sub = (lane == LANE_Y);
            end
         end
         default: ;
      endcase
      return ctrl;
   endfunction

endpackage

// File: rtl/pt3_if.sv
// ----------------------------------------------------------------------------
// Point transform 3D channel interfaces
// Valid/ready channels for input points and transformed results.
// ----------------------------------------------------------------------------
interface pt3_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;

   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface pt3_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_z;
   logic              clipped;

   modport source (output valid, new_x, new_y, new_z, clipped, input ready);
   modport sink   (input valid, new_x, new_y, new_z, clipped, output ready);
endinterface

// File: rtl/pt3_csr.sv
// ----------------------------------------------------------------------------
// Point transform 3D configuration registers
// Write-only register bank for mode, center/offset and factors.
// ----------------------------------------------------------------------------
module pt3_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  pt3_pkg::csr_index_type csr_index,
   input  pt3_pkg::csr_data_type csr_wdata,
   output pt3_pkg::cfg_type      cfg
);
   import pt3_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_MODE:     cfg_in.mode        = csr_wdata[2:0];
            REG_OFFSET_X: cfg_in.off[LANE_X] = csr_wdata;
            REG_OFFSET_Y: cfg_in.off[LANE_Y] = csr_wdata;
            REG_OFFSET_Z: cfg_in.off[LANE_Z] = csr_wdata;
            REG_FACTOR_A: cfg_in.fa          = csr_wdata[19:0];
            REG_FACTOR_B: cfg_in.fb          = csr_wdata[19:0];
            default: ;    // drop writes past the last register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_MOVE;
         cfg_ff.off  <= '0;
         cfg_ff.fa   <= FACTOR_ONE;
         cfg_ff.fb   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pt3_center.sv
// ----------------------------------------------------------------------------
// Point transform 3D centering stage
// Subtract the center from each coordinate and decode the lane operations.
// ----------------------------------------------------------------------------
module pt3_center (
   input  logic                       clock,
   input  logic                       load,
   input  pt3_pkg::coord_vec_type     pos,
   input  pt3_pkg::cfg_type           cfg,
   output pt3_pkg::diff_vec_type      d,
   output pt3_pkg::coord_vec_type     p,
   output pt3_pkg::lane_ctrl_vec_type ctrl
);
   import pt3_pkg::*;

   diff_vec_type      d_ff, d_in;
   coord_vec_type     p_ff;
   lane_ctrl_vec_type ctrl_ff, ctrl_in;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         d_in[i]    = {pos[i][31], pos[i]} - {cfg.off[i][31], cfg.off[i]};
         ctrl_in[i] = lane_decode(cfg.mode, lane_idx_type'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         d_ff    <= d_in;
         p_ff    <= pos;
         ctrl_ff <= ctrl_in;
      end
   end

   assign d    = d_ff;
   assign p    = p_ff;
   assign ctrl = ctrl_ff;

endmodule

// File: rtl/pt3_lane.sv
// ----------------------------------------------------------------------------
// Point transform 3D coordinate lane
// Two products, then sum, floor shift and offset add-back for one coordinate.
// ----------------------------------------------------------------------------
module pt3_lane (
   input  logic                  clock,
   input  logic                  load2,
   input  logic                  load3,
   input  pt3_pkg::diff_type     d_own,
   input  pt3_pkg::diff_vec_type d_vec,
   input  pt3_pkg::coord_type    p,
   input  pt3_pkg::lane_ctrl_type ctrl,
   input  pt3_pkg::factor_type   fa,
   input  pt3_pkg::factor_type   fb,
   input  pt3_pkg::coord_type    off,
   output pt3_pkg::wide_type     r
);
   import pt3_pkg::*;

   diff_type      d_b;
   factor_type    fb_eff;
   prod_type      pa_ff, pa_in, pb_ff, pb_in;
   coord_type     p2_ff;
   lane_ctrl_type ctrl2_ff;
   sum_type       sum;
   logic signed [37:0] shifted;
   wide_type      r_ff, r_in;

   // Stage 2: multiply
   always_comb begin
      case (ctrl.b_src)
         LANE_X:  d_b = d_vec[LANE_X];
         LANE_Y:  d_b = d_vec[LANE_Y];
         LANE_Z:  d_b = d_vec[LANE_Z];
         default: d_b = '0;
      endcase
      fb_eff = ctrl.b_en ? fb : '0;
      pa_in  = d_own * fa;
      pb_in  = d_b * fb_eff;
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         p2_ff    <= p;
         ctrl2_ff <= ctrl;
      end
   end

   // Stage 3: combine, round toward minus infinity, add the center back
   always_comb begin
      sum     = ctrl2_ff.b_sub ? ({pa_ff[52], pa_ff} - {pb_ff[52], pb_ff})
                               : ({pa_ff[52], pa_ff} + {pb_ff[52], pb_ff});
      shifted = sum[53:FRAC_BITS];
      case (ctrl2_ff.kind)
         KIND_XFORM: r_in = {shifted[37], shifted} + {{7{off[31]}}, off};
         KIND_MOVE:  r_in = {{7{p2_ff[31]}}, p2_ff} + {{7{off[31]}}, off};
         default:    r_in = {{7{p2_ff[31]}}, p2_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         r_ff <= r_in;
      end
   end

   assign r = r_ff;

endmodule

// File: rtl/pt3_sat.sv
// ----------------------------------------------------------------------------
// Point transform 3D saturation stage
// Clamp each coordinate to 32 bits and flag any clamp; output register.
// ----------------------------------------------------------------------------
module pt3_sat (
   input  logic                   clock,
   input  logic                   load,
   input  pt3_pkg::wide_vec_type  r,
   output pt3_pkg::coord_vec_type q,
   output logic                   clipped
);
   import pt3_pkg::*;

   coord_vec_type q_ff, q_in;
   logic          clip_ff, clip_in;
   logic          ovf;

   always_comb begin
      clip_in = 1'b0;
      ovf     = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         // in range only when the top eight bits all match the sign
         ovf = (r[i][38:31] != {8{r[i][38]}});
         if (ovf) begin
            q_in[i] = r[i][38] ? COORD_MIN : COORD_MAX;
         end else begin
            q_in[i] = r[i][31:0];
         end
         clip_in = clip_in | ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         q_ff    <= q_in;
         clip_ff <= clip_in;
      end
   end

   assign q       = q_ff;
   assign clipped = clip_ff;

endmodule

// File: rtl/point_transform_3d.sv
// ----------------------------------------------------------------------------
// Point transform 3D
// Move, scale or rotate a Q16.16 point about a programmable center.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          transaction
//  req_chan  in   pos_x, pos_y, pos_z              valid & ready
//  rsp_chan  out  new_x, new_y, new_z, clipped     valid & ready
//  csr_*     in   csr_index, csr_wdata             csr_wen
//
//  Four register stages: center, multiply, sum/shift/add-back, saturate.
//  One transaction per cycle sustained while rsp_chan is ready; the 33x20
//  multipliers (two per lane) in stage 2 set the stage depth.
//  Reset (synchronous, active high) empties the pipeline and loads the
//  register defaults: move mode, zero offsets, factor_a = 1.0, factor_b = 0.
//  Each stage holds while the next one is full and stalled; empty stages
//  keep filling, so input is taken while a result waits on rsp_chan.
// ----------------------------------------------------------------------------
`include "point_transform_3d_defines.svh"

module point_transform_3d (
   input  logic                   clock,
   input  logic                   reset,
   pt3_req_if.sink                req_chan,
   pt3_rsp_if.source              rsp_chan,
   input  logic                   csr_wen,
   input  pt3_pkg::csr_index_type csr_index,
   input  pt3_pkg::csr_data_type  csr_wdata
);
   import pt3_pkg::*;

   cfg_type           cfg;
   coord_vec_type     pos;
   diff_vec_type      d1;
   coord_vec_type     p1;
   lane_ctrl_vec_type ctrl1;
   wide_vec_type      r3;
   coord_vec_type     q4;
   logic              clip4;

   // stage valid bits travel alongside the data
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // A stage may load when it is empty or its contents move on this cycle.
   assign rdy4 = !v4_ff || rsp_chan.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_chan.ready = rdy1;

   always_comb begin
      v1_in = rdy1 ? req_chan.valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Register bank; software writes only while the pipeline is drained (not enforced here).
   pt3_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign pos[LANE_X] = req_chan.pos_x;
   assign pos[LANE_Y] = req_chan.pos_y;
   assign pos[LANE_Z] = req_chan.pos_z;

   // Stage 1: subtract the center, decode what each lane does.
   pt3_center u_center (
      .clock (clock),
      .load  (rdy1 && req_chan.valid),
      .pos   (pos),
      .cfg   (cfg),
      .d     (d1),
      .p     (p1),
      .ctrl  (ctrl1)
   );

   // Stages 2 and 3: one lane per coordinate; rotations cross-feed lanes.
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      pt3_lane u_lane (
         .clock (clock),
         .load2 (rdy2 && v1_ff),
         .load3 (rdy3 && v2_ff),
         .d_own (d1[i]),
         .d_vec (d1),
         .p     (p1[i]),
         .ctrl  (ctrl1[i]),
         .fa    (cfg.fa),
         .fb    (cfg.fb),
         .off   (cfg.off[i]),
         .r     (r3[i])
      );
   end

   // Stage 4: saturate and flag; this is the output register.
   pt3_sat u_sat (
      .clock   (clock),
      .load    (rdy4 && v3_ff),
      .r       (r3),
      .q       (q4),
      .clipped (clip4)
   );

   assign rsp_chan.valid   = v4_ff;
   assign rsp_chan.new_x   = q4[LANE_X];
   assign rsp_chan.new_y   = q4[LANE_Y];
   assign rsp_chan.new_z   = q4[LANE_Z];
   assign rsp_chan.clipped = clip4;

   // An accepted transaction always lands in stage 1.
   `PT3_ASSERT_NEXT(a_accept_fills_s1, req_chan.valid && req_chan.ready, v1_ff,
      "accepted transaction lost at stage 1")
   // A stage-2 item moving on must appear in stage 3.
   `PT3_ASSERT_NEXT(a_s2_to_s3, v2_ff && rdy3, v3_ff,
      "transaction dropped between stage 2 and stage 3")
   // Hold stage 3 while stage 4 is stalled.
   `PT3_ASSERT_NEXT(a_s3_hold, v3_ff && !rdy4, v3_ff,
      "stage 3 lost its transaction during a stall")
   // A clip flag needs at least one coordinate at a rail.
   `PT3_ASSERT_SAME(a_clip_rail, rsp_chan.valid && rsp_chan.clipped,
      (rsp_chan.new_x == COORD_MAX) || (rsp_chan.new_x == COORD_MIN) ||
      (rsp_chan.new_y == COORD_MAX) || (rsp_chan.new_y == COORD_MIN) ||
      (rsp_chan.new_z == COORD_MAX) || (rsp_chan.new_z == COORD_MIN),
      "clipped set with no saturated coordinate")

endmodule
